FILE: hw/rtl/pphd_pkg.sv
package pphd_pkg;

  // CORDIC geometry
  localparam int CORDIC_STEPS = 21;
  localparam int PRE_SHIFT    = 24;
  localparam int ANG_FRAC     = 16;
  // angle accumulator width, signed; |z| stays below 2^23
  localparam int ZW           = 25;

  // atan(2^-i) in degrees, scaled by 2^16, rounded
  localparam logic [ZW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    25'd2949120, 25'd1740967, 25'd919879, 25'd466945, 25'd234379,
    25'd117304,  25'd58666,   25'd29335,  25'd14668,  25'd7334,
    25'd3667,    25'd1833,    25'd917,    25'd458,    25'd229,
    25'd115,     25'd57,      25'd29,     25'd14,     25'd7,
    25'd4
  };

  // how the angle a is obtained for one item
  typedef enum logic [1:0] {
    KIND_CORDIC = 2'd0,  // both differences nonzero
    KIND_ZERO   = 2'd1,  // dy == 0 (includes identical points)
    KIND_AXIS   = 2'd2   // dx == 0, dy != 0
  } kind_t;

  typedef struct packed {
    logic  dx_neg;
    logic  dy_neg;
    kind_t kind;
  } ctl_t;

endpackage

FILE: hw/rtl/pphd_cordic_stage.sv
module pphd_cordic_stage #(
  parameter int W    = 37,
  parameter int STEP = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  logic signed [W-1:0]         x_in,
  input  logic signed [W-1:0]         y_in,
  input  logic signed [pphd_pkg::ZW-1:0] z_in,
  input  pphd_pkg::ctl_t              ctl_in,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output logic signed [W-1:0]         x_out,
  output logic signed [W-1:0]         y_out,
  output logic signed [pphd_pkg::ZW-1:0] z_out,
  output pphd_pkg::ctl_t              ctl_out
);

  logic signed [W-1:0]            xs, ys;
  logic signed [pphd_pkg::ZW-1:0] ang;
  logic signed [W-1:0]            x_nxt, y_nxt;
  logic signed [pphd_pkg::ZW-1:0] z_nxt;
  logic                           valid_r;
  logic signed [W-1:0]            x_r, y_r;
  logic signed [pphd_pkg::ZW-1:0] z_r;
  pphd_pkg::ctl_t                 ctl_r;

  assign xs  = x_in >>> STEP;
  assign ys  = y_in >>> STEP;
  assign ang = signed'(pphd_pkg::ATAN_TAB[STEP]);

  // rotate toward the x axis
  always_comb begin
    if (y_in > 0) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ang;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ang;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      ctl_r <= ctl_in;
    end
  end

  assign dn_valid = valid_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;
  assign ctl_out  = ctl_r;

endmodule

FILE: hw/rtl/point_pair_heading_degrees.sv
// Heading from a start point to an end point, in 1/2^FRAC_BITS degree.
//
// Input channel (in_*): one item carries start_x, start_y, end_x, end_y.
// Output channel (out_*): one item carries the heading, 0 up to below 360
// degrees; 90 points along +x, 180 along +y, 0 along -y, 270 along -x.
// Every input item gives exactly one output item, in order.
//
// Pipeline: 24 register stages (difference, magnitude, 21 CORDIC vectoring
// stages, final mapping). Throughput: one item per cycle while the
// receiver keeps out_tready high; each CORDIC iteration owns a register
// stage, so a new pair can enter every cycle unless the pipeline is stalled.
//
// Each stage holds a valid bit. When the receiver stalls, items pile up
// behind the output register and fill any empty stages first; in_tready
// falls only once every stage is full. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; the pipeline is
// empty and ready on the first cycle after reset.
module point_pair_heading_degrees #(
  parameter int COORD_BITS = 10,
  parameter int FRAC_BITS  = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // start_x, start_y, end_x, end_y (COORD_BITS each), zero fill to bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // heading [15:0]
  output logic [15:0]          out_tdata
);

  localparam int STEPS = pphd_pkg::CORDIC_STEPS;
  localparam int ZW    = pphd_pkg::ZW;
  localparam int DW    = COORD_BITS + 1;                       // signed difference
  localparam int W     = COORD_BITS + pphd_pkg::PRE_SHIFT + 3; // CORDIC x/y
  localparam int SHIFT = pphd_pkg::ANG_FRAC - FRAC_BITS;
  localparam int HW    = ZW + 2;
  localparam logic [HW-1:0] A90 = HW'(90) << FRAC_BITS;

  // ---- stage A: coordinate differences ----
  logic [COORD_BITS-1:0]  sx, sy, ex, ey;
  logic                   a_valid_r, a_ready;
  logic signed [DW-1:0]   dx_r, dy_r;

  assign sx = in_tdata[COORD_BITS-1:0];
  assign sy = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign ex = in_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign ey = in_tdata[4*COORD_BITS-1:3*COORD_BITS];

  logic b_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_tready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && a_ready) begin
      dx_r <= signed'({1'b0, ex}) - signed'({1'b0, sx});
      dy_r <= signed'({1'b0, ey}) - signed'({1'b0, sy});
    end
  end

  // ---- stage B: magnitudes, case split, CORDIC seed ----
  logic                 b_valid_r;
  logic [DW-1:0]        adx, ady;
  pphd_pkg::ctl_t       ctl_nxt, b_ctl_r;
  logic signed [W-1:0]  b_x_r, b_y_r;

  assign adx = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign ady = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);

  always_comb begin
    ctl_nxt.dx_neg = dx_r[DW-1];
    ctl_nxt.dy_neg = dy_r[DW-1];
    if (dy_r == '0) begin
      ctl_nxt.kind = pphd_pkg::KIND_ZERO;
    end else if (dx_r == '0) begin
      ctl_nxt.kind = pphd_pkg::KIND_AXIS;
    end else begin
      ctl_nxt.kind = pphd_pkg::KIND_CORDIC;
    end
  end

  logic c_ready [STEPS+1];
  assign b_ready = !b_valid_r || c_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_x_r   <= signed'(W'(adx) << pphd_pkg::PRE_SHIFT);
      b_y_r   <= signed'(W'(ady) << pphd_pkg::PRE_SHIFT);
      b_ctl_r <= ctl_nxt;
    end
  end

  // ---- CORDIC stages, one iteration each ----
  logic                 c_valid [STEPS+1];
  logic signed [W-1:0]  cx      [STEPS+1];
  logic signed [W-1:0]  cy      [STEPS+1];
  logic signed [ZW-1:0] cz      [STEPS+1];
  pphd_pkg::ctl_t       cctl    [STEPS+1];

  assign c_valid[0] = b_valid_r;
  assign cx[0]      = b_x_r;
  assign cy[0]      = b_y_r;
  assign cz[0]      = '0;
  assign cctl[0]    = b_ctl_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    pphd_cordic_stage #(
      .W    (W),
      .STEP (i)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .x_in     (cx[i]),
      .y_in     (cy[i]),
      .z_in     (cz[i]),
      .ctl_in   (cctl[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .x_out    (cx[i+1]),
      .y_out    (cy[i+1]),
      .z_out    (cz[i+1]),
      .ctl_out  (cctl[i+1])
    );
  end

  // ---- final stage: clamp angle, map quadrant to heading ----
  logic             f_valid_r, f_ready;
  logic [15:0]      heading_r;
  logic [15:0]      heading_nxt;
  logic [ZW-1:0]    z_pos;
  logic [HW-1:0]    a_val;
  logic [HW-1:0]    h_full;
  pphd_pkg::ctl_t   fctl;

  assign fctl = cctl[STEPS];

  always_comb begin
    // negative angle floors to zero; the top stays below the axis value
    z_pos = cz[STEPS][ZW-1] ? '0 : unsigned'(cz[STEPS]);
    a_val = HW'(z_pos >> SHIFT);
    if (a_val > A90 - HW'(1)) begin
      a_val = A90 - HW'(1);
    end
    case (fctl.kind)
      pphd_pkg::KIND_ZERO: a_val = '0;
      pphd_pkg::KIND_AXIS: a_val = A90;
      default:             ;
    endcase
    if (!fctl.dx_neg) begin
      h_full = fctl.dy_neg ? (A90 - a_val) : (A90 + a_val);
    end else begin
      h_full = fctl.dy_neg ? (HW'(3) * A90 + a_val) : (HW'(3) * A90 - a_val);
    end
    heading_nxt = h_full[15:0];
  end

  assign f_ready          = !f_valid_r || out_tready;
  assign c_ready[STEPS]   = f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (f_ready) begin
      f_valid_r <= c_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid[STEPS] && f_ready) begin
      heading_r <= heading_nxt;
    end
  end

  assign out_tvalid = f_valid_r;
  assign out_tdata  = heading_r;

endmodule
